[hw/rtl/dlte_pkg.sv]
// Package for the delta-list timer engine: command codes, slot states,
// controller states and the command/status structs. No dependencies.
package dlte_pkg;

    localparam int unsigned NumSlotsDef = 16;
    localparam int unsigned TimeW       = 31;
    localparam int unsigned PeriodW     = 16;
    localparam int unsigned IdW         = 4;
    localparam int unsigned KindW       = 3;
    localparam logic [PeriodW-1:0] PeriodRst = 16'd10;
    localparam logic [1:0] RegPeriod = 2'd0;

    typedef enum logic [2:0] {
        K_TICK    = 3'd0,
        K_START_S = 3'd1,
        K_START_I = 3'd2,
        K_STOP    = 3'd3,
        K_SUSP    = 3'd4,
        K_RESUME  = 3'd5,
        K_QUERY   = 3'd6,
        K_NONE    = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RUN  = 2'd1,
        S_SUSP = 2'd2,
        S_RSVD = 2'd3
    } t_slot_st;

    typedef enum logic [3:0] {
        C_IDLE,
        C_DIV,
        C_TICK_DEC,
        C_TICK_FIND,
        C_TICK_POP,
        C_TICK_CNT,
        C_TICK_LINK,
        C_TICK_OUT,
        C_CMD_UNLINK,
        C_CMD_CNT,
        C_CMD_LINK,
        C_CMD_OUT
    } t_ctrl_st;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the input transaction
        logic div_start;
        logic dec_all;    // count every running slot down
        logic find_top;   // latch the front slot of the list
        logic pop_top;    // unlink front slot; reload or idle
        logic cmd_apply;  // unlink/arm/state change for a command
        logic cnt_start;  // begin a link-position count
        logic cnt_step;
        logic link;       // link the selected slot at the counted position
        logic out_load;   // load the output register
        logic out_exp;    // output is an expiry notice
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic cnt_done;
        logic top_exp;    // a running slot at the front has reached zero
        logic top_relink; // that slot is an interval slot
        logic need_div;   // command is a start on a present slot
        logic need_link;  // command links its slot (start, resume of suspended)
        logic need_unlink;
        logic is_tick;
        logic is_none;
        logic out_busy;
    } t_sts;

endpackage

[hw/rtl/dlte_div.sv]
// Restoring divider, one quotient bit per cycle, for ms-to-ticks conversion.
// Depends on dlte_pkg.
module dlte_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dlte_pkg::TimeW-1:0]   i_num,
    input  logic [dlte_pkg::PeriodW-1:0] i_den,
    output logic                         o_done,
    output logic [dlte_pkg::TimeW-1:0]   o_quot
);
    import dlte_pkg::*;

    localparam int unsigned CntW = $clog2(TimeW + 1);

    logic [TimeW-1:0]  r_q, n_q;
    logic [PeriodW:0]  r_rem, n_rem;
    logic [PeriodW-1:0] r_den;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic [PeriodW:0]  w_trial;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem[PeriodW-1:0], r_q[TimeW-1]};
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = CntW'(TimeW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_q   = {r_q[TimeW-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[TimeW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= (i_den == '0) ? PeriodW'(1) : i_den;
        end
    end

    assign o_done = !r_busy && !i_start;
    assign o_quot = r_q;
endmodule

[hw/rtl/dlte_datapath.sv]
// Slot bank, list ranks, position counter and output register.
// Depends on dlte_pkg and dlte_div.
module dlte_datapath #(
    parameter int unsigned NUM_SLOTS = dlte_pkg::NumSlotsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dlte_pkg::t_cmd               i_cmd,
    output dlte_pkg::t_sts               o_sts,
    input  logic [dlte_pkg::KindW-1:0]   i_kind,
    input  logic [dlte_pkg::IdW-1:0]     i_timer_id,
    input  logic [dlte_pkg::TimeW-1:0]   i_time_ms,
    input  logic [dlte_pkg::PeriodW-1:0] i_period,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_result_kind,
    output logic [dlte_pkg::IdW-1:0]     o_slot_id,
    output logic                         o_status,
    output logic [dlte_pkg::TimeW-1:0]   o_remaining_ticks,
    output logic                         o_last
);
    import dlte_pkg::*;

    localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

    logic [TimeW-1:0] r_rem   [NUM_SLOTS];
    logic [TimeW-1:0] r_rld   [NUM_SLOTS];
    logic             r_intv  [NUM_SLOTS];
    t_slot_st         r_st    [NUM_SLOTS];
    logic [SW-1:0]    r_rank  [NUM_SLOTS];

    t_kind            r_kind;
    logic [IdW-1:0]   r_id;
    logic [TimeW-1:0] r_ms;
    logic [SW-1:0]    r_sel;     // slot being worked on
    logic [CW-1:0]    r_ci;      // count sweep index
    logic [CW-1:0]    r_pos;
    logic             r_cbusy;
    logic             r_ov;
    logic             r_okind, r_ostat, r_olast;
    logic [IdW-1:0]   r_oid;
    logic [TimeW-1:0] r_orem;

    logic             w_present;
    logic [SW-1:0]    w_idx;
    t_slot_st         w_st;
    logic             w_div_done;
    logic [TimeW-1:0] w_quot;
    logic [TimeW-1:0] w_ticks;
    logic             w_top_hit;
    logic [SW-1:0]    w_top;
    logic             w_top_exp;
    logic [SW-1:0]    w_ci;

    assign w_present = ({{(32-IdW){1'b0}}, r_id} < NUM_SLOTS);
    assign w_idx     = SW'(r_id);
    assign w_st      = r_st[w_idx];
    assign w_ci      = r_ci[SW-1:0];

    dlte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_ms),
        .i_den   (i_period),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ms below period (period 0 acts as 1) gives one tick
    assign w_ticks = ({1'b0, r_ms} < {{(TimeW-PeriodW+1){1'b0}},
                      ((i_period == '0) ? PeriodW'(1) : i_period)}) ? TimeW'(1) : w_quot;

    always_comb begin
        w_top_hit = 1'b0;
        w_top     = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_st[i] == S_RUN && r_rank[i] == '0) begin
                w_top_hit = 1'b1;
                w_top     = SW'(i);
            end
        end
    end

    // front of the list has run out, judged on the current slot state
    assign w_top_exp = w_top_hit && r_rem[w_top] == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_rem[i]  <= '0;
                r_rld[i]  <= '0;
                r_intv[i] <= 1'b0;
                r_st[i]   <= S_IDLE;
                r_rank[i] <= '0;
            end
            r_cbusy  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_kind <= t_kind'(i_kind);
                r_id   <= i_timer_id;
                r_ms   <= i_time_ms;
                r_sel  <= SW'(i_timer_id);
            end
            if (i_cmd.dec_all) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (r_st[i] == S_RUN && r_rem[i] != '0) begin
                        r_rem[i] <= r_rem[i] - 1'b1;
                    end
                end
            end
            if (i_cmd.find_top) begin
                r_sel    <= w_top;
            end
            if (i_cmd.pop_top) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (SW'(i) != r_sel && r_st[i] == S_RUN && r_rank[i] != '0) begin
                        r_rank[i] <= r_rank[i] - 1'b1;
                    end
                end
                r_rank[r_sel] <= '0;
                if (r_intv[r_sel]) begin
                    r_rem[r_sel] <= r_rld[r_sel];
                end else begin
                    r_st[r_sel] <= S_IDLE;
                end
            end
            if (i_cmd.cmd_apply) begin
                if (w_st == S_RUN && (r_kind == K_START_S || r_kind == K_START_I
                        || r_kind == K_STOP || r_kind == K_SUSP)) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (SW'(i) != w_idx && r_st[i] == S_RUN && r_rank[i] > r_rank[w_idx]) begin
                            r_rank[i] <= r_rank[i] - 1'b1;
                        end
                    end
                    r_rank[w_idx] <= '0;
                end
                unique case (r_kind)
                    K_START_S, K_START_I: begin
                        r_intv[w_idx] <= (r_kind == K_START_I);
                        r_rld[w_idx]  <= w_ticks;
                        r_rem[w_idx]  <= w_ticks;
                        r_st[w_idx]   <= S_IDLE;  // relinked by the count pass
                    end
                    K_STOP: begin
                        r_st[w_idx] <= S_IDLE;
                    end
                    K_SUSP: begin
                        if (w_st == S_RUN) begin
                            r_st[w_idx] <= S_SUSP;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.cnt_start) begin
                r_cbusy <= 1'b1;
                r_ci    <= '0;
                r_pos   <= '0;
            end else if (i_cmd.cnt_step && r_cbusy) begin
                if (w_ci != r_sel && r_st[w_ci] == S_RUN && r_rem[w_ci] <= r_rem[r_sel]) begin
                    r_pos <= r_pos + 1'b1;
                end
                r_ci <= r_ci + 1'b1;
                if (r_ci == CW'(NUM_SLOTS - 1)) begin
                    r_cbusy <= 1'b0;
                end
            end
            if (i_cmd.link) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (SW'(i) != r_sel && r_st[i] == S_RUN
                            && {1'b0, r_rank[i]} >= r_pos) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                r_rank[r_sel] <= r_pos[SW-1:0];
                r_st[r_sel]   <= S_RUN;
            end
            if (i_cmd.out_load) begin
                r_ov    <= 1'b1;
                r_olast <= 1'b1;
                r_orem  <= '0;
                if (i_cmd.out_exp) begin
                    r_okind <= 1'b0;
                    r_oid   <= IdW'(r_sel);
                    r_ostat <= 1'b0;
                    r_olast <= !w_top_exp;
                end else begin
                    r_okind <= 1'b1;
                    r_oid   <= r_id;
                    r_ostat <= 1'b0;
                    if (!w_present) begin
                        r_ostat <= 1'b1;
                    end else begin
                        unique case (r_kind)
                            K_START_S, K_START_I: r_ostat <= 1'b0;
                            K_QUERY: begin
                                if (w_st == S_RUN || w_st == S_SUSP) begin
                                    r_orem <= r_rem[w_idx];
                                end else begin
                                    r_ostat <= 1'b1;
                                end
                            end
                            default: r_ostat <= !(w_st == S_RUN || w_st == S_SUSP);
                        endcase
                    end
                end
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // note: command status is built from the slot state before the apply edge
    always_comb begin
        o_sts.div_done    = w_div_done;
        o_sts.cnt_done    = !r_cbusy;
        o_sts.top_exp     = w_top_exp;
        o_sts.top_relink  = r_intv[r_sel];
        o_sts.is_tick     = (r_kind == K_TICK);
        o_sts.is_none     = (r_kind == K_NONE);
        o_sts.need_div    = w_present && (r_kind == K_START_S || r_kind == K_START_I);
        o_sts.need_link   = w_present && ((r_kind == K_START_S || r_kind == K_START_I)
                            || (r_kind == K_RESUME && w_st == S_SUSP));
        o_sts.need_unlink = w_present && r_kind != K_RESUME && r_kind != K_QUERY;
        o_sts.out_busy    = r_ov && !i_ready;
    end

    assign o_valid           = r_ov;
    assign o_result_kind     = r_okind;
    assign o_slot_id         = r_oid;
    assign o_status          = r_ostat;
    assign o_remaining_ticks = r_orem;
    assign o_last            = r_olast;
endmodule

[hw/rtl/dlte_ctrl.sv]
// Sequencer for ticks and commands. Drives the datapath command struct.
// Depends on dlte_pkg.
module dlte_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dlte_pkg::t_sts i_sts,
    output dlte_pkg::t_cmd o_cmd
);
    import dlte_pkg::*;

    t_ctrl_st r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:       if (i_valid) n_state = C_DIV;
            C_DIV: begin
                if (i_sts.is_tick) begin
                    n_state = C_TICK_DEC;
                end else if (i_sts.is_none) begin
                    n_state = C_IDLE;
                end else if (i_sts.need_div) begin
                    n_state = C_CMD_UNLINK;
                end else if (i_sts.need_link) begin
                    n_state = C_CMD_CNT;
                end else begin
                    n_state = C_CMD_OUT;
                end
            end
            C_TICK_DEC:   n_state = C_TICK_FIND;
            C_TICK_FIND:  n_state = i_sts.top_exp ? C_TICK_POP : C_IDLE;
            C_TICK_POP:   n_state = i_sts.top_relink ? C_TICK_CNT : C_TICK_OUT;
            C_TICK_CNT:   if (i_sts.cnt_done) n_state = C_TICK_LINK;
            C_TICK_LINK:  n_state = C_TICK_OUT;
            C_TICK_OUT:   if (!i_sts.out_busy) n_state = C_TICK_FIND;
            C_CMD_UNLINK: if (i_sts.div_done) n_state = C_CMD_CNT;
            C_CMD_CNT:    if (i_sts.cnt_done) n_state = C_CMD_LINK;
            C_CMD_LINK:   n_state = C_CMD_OUT;
            C_CMD_OUT:    if (!i_sts.out_busy) n_state = C_IDLE;
            default:      n_state = C_IDLE;
        endcase
    end

    // Resume of a suspended slot runs the position count and links first.
    // Other non-start commands: status is built in C_CMD_OUT from the
    // pre-change state, then applied in the same edge.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            C_IDLE: begin
                o_ready  = 1'b1;
                o_cmd.load = i_valid;
            end
            C_DIV: begin
                o_cmd.div_start = i_sts.need_div;
                o_cmd.cnt_start = i_sts.need_link && !i_sts.need_div;
            end
            C_TICK_DEC:  o_cmd.dec_all = 1'b1;
            C_TICK_FIND: o_cmd.find_top = 1'b1;
            C_TICK_POP: begin
                o_cmd.pop_top   = 1'b1;
                o_cmd.cnt_start = 1'b1;
            end
            C_TICK_CNT:  o_cmd.cnt_step = 1'b1;
            C_TICK_LINK: o_cmd.link = 1'b1;
            C_TICK_OUT: begin
                o_cmd.out_load = !i_sts.out_busy;
                o_cmd.out_exp  = 1'b1;
                o_cmd.find_top = !i_sts.out_busy;
            end
            C_CMD_UNLINK: begin
                o_cmd.cmd_apply = i_sts.div_done;
                o_cmd.cnt_start = i_sts.div_done;
            end
            C_CMD_CNT:   o_cmd.cnt_step = 1'b1;
            C_CMD_LINK:  o_cmd.link = 1'b1;
            C_CMD_OUT: begin
                o_cmd.out_load  = !i_sts.out_busy;
                o_cmd.cmd_apply = !i_sts.out_busy && !i_sts.need_div && i_sts.need_unlink;
            end
            default: o_cmd = '0;
        endcase
    end
endmodule

[hw/rtl/delta_list_timer_engine_unit.sv]
// Top level of the delta-list timer engine: APB register, controller and datapath.
// Depends on dlte_pkg, dlte_ctrl, dlte_datapath, dlte_div.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | i_valid/o_ready, i_kind, i_timer_id, ...  | in
//  result  | o_valid/i_ready, o_result_kind ... o_last | out
//  config  | psel/penable/pwrite/paddr/pwdata/prdata   | in/out
//
// One transaction at a time, in these steps:
// Start: the divider runs, then the slot is unlinked, counted into position and linked.
// Tick: all running slots count down, then each expired front slot is popped; an
// interval slot is recounted and relinked. Resume of a suspended slot: count, link.
// Reset (synchronous, active low) idles every slot and sets the period to 10.
// A stalled result holds the sequencer in its output state.
module delta_list_timer_engine_unit #(
    parameter int unsigned NUM_SLOTS = dlte_pkg::NumSlotsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dlte_pkg::KindW-1:0]   i_kind,
    input  logic [dlte_pkg::IdW-1:0]     i_timer_id,
    input  logic [dlte_pkg::TimeW-1:0]   i_time_ms,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_result_kind,
    output logic [dlte_pkg::IdW-1:0]     o_slot_id,
    output logic                         o_status,
    output logic [dlte_pkg::TimeW-1:0]   o_remaining_ticks,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import dlte_pkg::*;

    logic [PeriodW-1:0] r_period;
    t_cmd               w_cmd;
    t_sts               w_sts;

    assign pready = 1'b1;
    // single register at byte address 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PeriodRst;
        end else if (psel && penable && pwrite && paddr == RegPeriod) begin
            r_period <= pwdata[PeriodW-1:0];
        end
    end
    assign prdata = (paddr == RegPeriod) ? {16'd0, r_period} : 32'd0;

    dlte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    dlte_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_kind            (i_kind),
        .i_timer_id        (i_timer_id),
        .i_time_ms         (i_time_ms),
        .i_period          (r_period),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_result_kind     (o_result_kind),
        .o_slot_id         (o_slot_id),
        .o_status          (o_status),
        .o_remaining_ticks (o_remaining_ticks),
        .o_last            (o_last)
    );

    // a stalled result holds its valid and payload
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable({o_result_kind, o_slot_id,
            o_status, o_remaining_ticks, o_last})))
        else $error("stalled result changed");
    // expiry notices never carry a count
    a_exp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result_kind) |-> (o_remaining_ticks == '0 && !o_status))
        else $error("expiry notice with nonzero fields");
    // a result with a nonzero remaining count must be the last one
    a_rem_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_remaining_ticks != '0) |-> o_last)
        else $error("count on non-final result");
endmodule

[sim/dlte_checker.sv]
// Checker for the delta-list timer engine: watches the command, result and register ports,
// predicts every result and compares it. Depends on dlte_pkg.
module dlte_checker #(
    parameter int unsigned NUM_SLOTS = dlte_pkg::NumSlotsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_in_ready,
    input  logic [dlte_pkg::KindW-1:0]   i_kind,
    input  logic [dlte_pkg::IdW-1:0]     i_timer_id,
    input  logic [dlte_pkg::TimeW-1:0]   i_time_ms,
    input  logic                         i_res_valid,
    input  logic                         i_ready,
    input  logic                         i_result_kind,
    input  logic [dlte_pkg::IdW-1:0]     i_slot_id,
    input  logic                         i_status,
    input  logic [dlte_pkg::TimeW-1:0]   i_remaining_ticks,
    input  logic                         i_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dlte_pkg::*;

    localparam logic RES_EXPIRY = 1'b0;
    localparam logic RES_STATUS = 1'b1;
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_NONE  = 1'b1;

    typedef struct packed {
        logic             rkind;
        logic [IdW-1:0]   id;
        logic             stat;
        logic [TimeW-1:0] rem;
        logic             last;
    } t_timer_res;

    t_timer_res       expected_q[$];
    logic [TimeW-1:0] ticks_left [NUM_SLOTS];
    logic [TimeW-1:0] reload_val [NUM_SLOTS];
    logic             is_ivl     [NUM_SLOTS];
    t_slot_st         slot_st    [NUM_SLOTS];
    int               rank       [NUM_SLOTS];
    logic [PeriodW-1:0] period;
    int               fails = 0;

    assign o_fail_count = fails;

    function automatic void unlink_slot(int s);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (i != s && slot_st[i] == S_RUN && rank[i] > rank[s]) rank[i]--;
        rank[s] = 0;
    endfunction

    // goes behind every running slot with a count <= its own
    function automatic void link_slot(int s);
        int pos;
        pos = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (i != s && slot_st[i] == S_RUN && ticks_left[i] <= ticks_left[s]) pos++;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (i != s && slot_st[i] == S_RUN && rank[i] >= pos) rank[i]++;
        rank[s]    = pos;
        slot_st[s] = S_RUN;
    endfunction

    function automatic logic [TimeW-1:0] ms_to_ticks(logic [TimeW-1:0] ms);
        logic [TimeW-1:0] p;
        p = (period == '0) ? TimeW'(1) : TimeW'(period);
        return (ms < p) ? TimeW'(1) : ms / p;
    endfunction

    function automatic void predict_timer(logic [KindW-1:0] kind, logic [IdW-1:0] id,
                                          logic [TimeW-1:0] ms);
        t_timer_res       batch [NUM_SLOTS];
        int               n;
        int               top;
        logic             done;
        logic             stat;
        logic [TimeW-1:0] rem;
        int               s;
        n    = 0;
        stat = STAT_OK;
        rem  = '0;
        s    = int'(id);
        case (t_kind'(kind))
            K_TICK: begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (slot_st[i] == S_RUN && ticks_left[i] > 0) ticks_left[i]--;
                done = 1'b0;
                for (int g = 0; g < NUM_SLOTS; g++) begin
                    top = -1;
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (top < 0 && slot_st[i] == S_RUN && rank[i] == 0) top = i;
                    if (top < 0) done = 1'b1;
                    else if (ticks_left[top] != 0) done = 1'b1;
                    if (!done) begin
                        unlink_slot(top);
                        if (is_ivl[top]) begin
                            ticks_left[top] = reload_val[top];
                            link_slot(top);
                        end else begin
                            slot_st[top] = S_IDLE;
                        end
                        batch[n] = '{RES_EXPIRY, IdW'(top), STAT_OK, '0, 1'b0};
                        n++;
                    end
                end
                if (n > 0) batch[n-1].last = 1'b1;
                for (int i = 0; i < n; i++) expected_q.push_back(batch[i]);
            end
            K_NONE: ;
            default: begin
                if (s >= NUM_SLOTS) begin
                    stat = STAT_NONE;
                end else begin
                    case (t_kind'(kind))
                        K_START_S, K_START_I: begin
                            if (slot_st[s] == S_RUN) unlink_slot(s);
                            is_ivl[s]     = (t_kind'(kind) == K_START_I);
                            reload_val[s] = ms_to_ticks(ms);
                            ticks_left[s] = reload_val[s];
                            link_slot(s);
                        end
                        K_STOP: begin
                            if (slot_st[s] == S_RUN) unlink_slot(s);
                            if (slot_st[s] == S_RUN || slot_st[s] == S_SUSP) slot_st[s] = S_IDLE;
                            else stat = STAT_NONE;
                        end
                        K_SUSP: begin
                            if (slot_st[s] == S_RUN) begin
                                unlink_slot(s);
                                slot_st[s] = S_SUSP;
                            end else if (slot_st[s] != S_SUSP) begin
                                stat = STAT_NONE;
                            end
                        end
                        K_RESUME: begin
                            if (slot_st[s] == S_SUSP) link_slot(s);
                            else if (slot_st[s] != S_RUN) stat = STAT_NONE;
                        end
                        default: begin
                            if (slot_st[s] == S_RUN || slot_st[s] == S_SUSP) rem = ticks_left[s];
                            else stat = STAT_NONE;
                        end
                    endcase
                end
                expected_q.push_back('{RES_STATUS, id, stat, rem, 1'b1});
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_timer_res want;
        if (!i_rst_n) begin
            expected_q.delete();
            period = PeriodRst;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                ticks_left[i] = '0;
                reload_val[i] = '0;
                is_ivl[i]     = 1'b0;
                slot_st[i]    = S_IDLE;
                rank[i]       = 0;
            end
        end else begin
            if (i_res_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: unexpected result kind=%0d slot=%0d", $realtime,
                                 i_result_kind, i_slot_id);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.rkind !== i_result_kind || want.id !== i_slot_id ||
                        want.stat !== i_status || want.rem !== i_remaining_ticks ||
                        want.last !== i_last) begin
                        if (fails < 10)
                            $display("%0t: mismatch exp kind=%0d slot=%0d st=%0d rem=%0d last=%0d got kind=%0d slot=%0d st=%0d rem=%0d last=%0d",
                                     $realtime, want.rkind, want.id, want.stat, want.rem,
                                     want.last, i_result_kind, i_slot_id, i_status,
                                     i_remaining_ticks, i_last);
                        fails++;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == RegPeriod)
                period = pwdata[PeriodW-1:0];
            if (i_valid && i_in_ready) predict_timer(i_kind, i_timer_id, i_time_ms);
        end
        o_pending = expected_q.size();
    end

endmodule

[sim/tb_top.sv]
// Testbench top for the delta-list timer engine: clock, reset, stimulus and verdict.
// Depends on dlte_pkg, delta_list_timer_engine_unit and dlte_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dlte_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 60;   // longer than any tick that expires nothing

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [KindW-1:0]   i_kind;
    logic [IdW-1:0]     i_timer_id;
    logic [TimeW-1:0]   i_time_ms;
    logic               o_valid;
    logic               i_ready;
    logic               o_result_kind;
    logic [IdW-1:0]     o_slot_id;
    logic               o_status;
    logic [TimeW-1:0]   o_remaining_ticks;
    logic               o_last;
    logic               psel, penable, pwrite, pready;
    logic [1:0]         paddr;
    logic [31:0]        pwdata, prdata;

    int fail_count;
    int pending;
    int cycles = 0;
    int stall_left = 0;
    logic quiet = 1'b0;         // no idling on either side
    int cur_period = 10;

    delta_list_timer_engine_unit i_dut (.*);

    dlte_checker i_chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_kind, .i_timer_id, .i_time_ms,
        .i_res_valid(o_valid), .i_ready, .i_result_kind(o_result_kind),
        .i_slot_id(o_slot_id), .i_status(o_status), .i_remaining_ticks(o_remaining_ticks),
        .i_last(o_last), .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side back-pressure in short random bursts
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(1, 4) - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // One command transaction; o_ready is read mid-cycle so the edge decides alone.
    task automatic send_cmd(t_kind kind, int id, logic [TimeW-1:0] ms);
        logic took;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_timer_id <= IdW'(id);
        i_time_ms  <= ms;
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    // drop valid, then wait for every expected result plus the tail of a silent tick
    task automatic settle_down();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_period(int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= RegPeriod;
        pwdata  <= 32'(value & 16'hFFFF);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_period = value;
    endtask

    // Mostly ticks and short starts so slots keep expiring and interval slots relink.
    task automatic random_cmd();
        int r;
        int per;
        logic [TimeW-1:0] ms;
        per = (cur_period == 0) ? 1 : cur_period;
        r   = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) ms = TimeW'($urandom);
        else ms = TimeW'($urandom_range(0, per * 6));
        if (r < 45) send_cmd(K_TICK, $urandom_range(0, 15), TimeW'($urandom));
        else if (r < 55) send_cmd(K_START_S, $urandom_range(0, 15), ms);
        else if (r < 66) send_cmd(K_START_I, $urandom_range(0, 15), ms);
        else if (r < 73) send_cmd(K_STOP, $urandom_range(0, 15), TimeW'($urandom));
        else if (r < 80) send_cmd(K_SUSP, $urandom_range(0, 15), TimeW'($urandom));
        else if (r < 87) send_cmd(K_RESUME, $urandom_range(0, 15), TimeW'($urandom));
        else if (r < 96) send_cmd(K_QUERY, $urandom_range(0, 15), TimeW'($urandom));
        else send_cmd(K_NONE, $urandom_range(0, 15), TimeW'($urandom));
    endtask

    int period_list [5] = '{1, 65535, 0, 3, 10};

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_kind     <= K_TICK;
        i_timer_id <= '0;
        i_time_ms  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset period of 10 ms
        send_cmd(K_START_S, 0, TimeW'(0));             // below one period: one tick
        send_cmd(K_START_I, 1, TimeW'(25));
        send_cmd(K_START_S, 15, {TimeW{1'b1}});        // largest delay
        send_cmd(K_QUERY, 15, '0);
        send_cmd(K_SUSP, 15, '0);
        send_cmd(K_SUSP, 15, '0);                      // already suspended
        send_cmd(K_QUERY, 15, '0);                     // suspended keeps its count
        send_cmd(K_RESUME, 15, '0);
        send_cmd(K_RESUME, 15, '0);                    // already running
        send_cmd(K_TICK, 15, {TimeW{1'b1}});
        send_cmd(K_TICK, 0, '0);
        send_cmd(K_STOP, 15, '0);
        send_cmd(K_STOP, 15, '0);                      // idle slot
        send_cmd(K_SUSP, 3, '0);
        send_cmd(K_RESUME, 3, '0);
        send_cmd(K_QUERY, 3, '0);
        send_cmd(K_NONE, 5, TimeW'(77));
        send_cmd(K_START_S, 0, TimeW'(9));
        send_cmd(K_START_I, 1, TimeW'(30));            // restart of a running slot
        send_cmd(K_START_I, 2, TimeW'(10));
        send_cmd(K_TICK, 0, '0);
        send_cmd(K_TICK, 0, '0);
        send_cmd(K_TICK, 0, '0);
        send_cmd(K_STOP, 1, '0);

        // random phases, one per period setting; the last runs without idling
        for (int p = 0; p < 5; p++) begin
            settle_down();
            write_period(period_list[p]);
            quiet = (p == 4);
            repeat (88) random_cmd();
        end

        settle_down();
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/dlte_pkg.sv
hw/rtl/dlte_div.sv
hw/rtl/dlte_datapath.sv
hw/rtl/dlte_ctrl.sv
hw/rtl/delta_list_timer_engine_unit.sv
sim/dlte_checker.sv
sim/tb_top.sv
